[sv/mfts_pkg.sv]
// Shared types, codes and sizes for the multilevel feedback task scheduler.
package mfts_pkg;

  localparam int SLOTS    = 16;
  localparam int SW       = $clog2(SLOTS);
  localparam int QUEUES   = 5;
  localparam int QW       = 3;
  localparam int CW       = $clog2(SLOTS + 1);
  localparam logic [QW-1:0] SLEEP_Q = 3'd4;

  localparam int IN_W  = 80;
  localparam int OUT_W = 16;

  // Task conditions.
  localparam logic [1:0] C_FREE    = 2'd0;
  localparam logic [1:0] C_READY   = 2'd1;
  localparam logic [1:0] C_RUN     = 2'd2;
  localparam logic [1:0] C_BLOCKED = 2'd3;

  // Commands.
  localparam logic [2:0] CMD_SCHED   = 3'd0;
  localparam logic [2:0] CMD_SPAWN   = 3'd1;
  localparam logic [2:0] CMD_SLEEP   = 3'd2;
  localparam logic [2:0] CMD_UNBLOCK = 3'd3;
  localparam logic [2:0] CMD_BLOCK   = 3'd4;
  localparam logic [2:0] CMD_EXIT    = 3'd5;

  // Result codes.
  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_NO_SLOT = 2'd1;
  localparam logic [1:0] RC_NOT_BLK = 2'd2;
  localparam logic [1:0] RC_NO_RDY  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLICE1 = 2'd0;
  localparam logic [1:0] CFG_SLICE2 = 2'd1;
  localparam logic [1:0] CFG_SLICE3 = 2'd2;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_LOAD   = 4'd1;
  localparam op_t OP_SPAWN  = 4'd2;
  localparam op_t OP_PRE    = 4'd3;
  localparam op_t OP_CUR    = 4'd4;
  localparam op_t OP_SPOP   = 4'd5;
  localparam op_t OP_SPUSH  = 4'd6;
  localparam op_t OP_PICK   = 4'd7;
  localparam op_t OP_REFILL = 4'd8;
  localparam op_t OP_WINIT  = 4'd9;
  localparam op_t OP_WSTEP  = 4'd10;
  localparam op_t OP_UNBLK  = 4'd11;
  localparam op_t OP_OUT    = 4'd12;

  typedef struct packed {
    op_t op;
  } mfts_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       sleep_nz;
    logic       pick_ok;
    logic       q0_nz;
    logic       walk_end;
    logic       out_free;
  } mfts_sts_t;

endpackage

[sv/mfts_ctrl.sv]
// Sequencer that steps the datapath through one scheduler command.
module mfts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mfts_pkg::mfts_sts_t sts,
  output mfts_pkg::mfts_ctl_t ctl
);
  import mfts_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SPAWN  = 4'd2;
  localparam logic [3:0] S_PRE    = 4'd3;
  localparam logic [3:0] S_CUR    = 4'd4;
  localparam logic [3:0] S_SPOP   = 4'd5;
  localparam logic [3:0] S_SPUSH  = 4'd6;
  localparam logic [3:0] S_PICK   = 4'd7;
  localparam logic [3:0] S_REFILL = 4'd8;
  localparam logic [3:0] S_WINIT  = 4'd9;
  localparam logic [3:0] S_WSTEP  = 4'd10;
  localparam logic [3:0] S_UNBLK  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_SCHED:   state_nxt = S_CUR;
          CMD_SPAWN:   state_nxt = S_SPAWN;
          CMD_SLEEP:   state_nxt = S_PRE;
          CMD_UNBLOCK: state_nxt = S_WINIT;
          CMD_BLOCK:   state_nxt = S_PRE;
          CMD_EXIT:    state_nxt = S_PRE;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_SPAWN: begin
        ctl.op    = OP_SPAWN;
        state_nxt = S_DONE;
      end
      S_PRE: begin
        ctl.op    = OP_PRE;
        state_nxt = S_CUR;
      end
      S_CUR: begin
        ctl.op    = OP_CUR;
        state_nxt = S_SPOP;
      end
      S_SPOP: begin
        if (sts.sleep_nz) begin
          ctl.op    = OP_SPOP;
          state_nxt = S_SPUSH;
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_SPUSH: begin
        ctl.op    = OP_SPUSH;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        ctl.op = OP_PICK;
        if (!sts.pick_ok && sts.q0_nz) state_nxt = S_REFILL;
        else state_nxt = S_DONE;
      end
      S_REFILL: begin
        if (sts.q0_nz) ctl.op = OP_REFILL;
        else state_nxt = S_PICK;
      end
      S_WINIT: begin
        ctl.op    = OP_WINIT;
        state_nxt = S_WSTEP;
      end
      S_WSTEP: begin
        if (sts.walk_end) state_nxt = S_UNBLK;
        else ctl.op = OP_WSTEP;
      end
      S_UNBLK: begin
        ctl.op    = OP_UNBLK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[sv/mfts_dp.sv]
// Task tables, ready and sleep queues, and result register of the scheduler.
module mfts_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mfts_pkg::mfts_ctl_t         ctl,
  output mfts_pkg::mfts_sts_t         sts,
  input  logic [mfts_pkg::IN_W-1:0]   in_tdata,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_addr,
  input  logic [7:0]                  cfg_wdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mfts_pkg::OUT_W-1:0]  out_tdata
);
  import mfts_pkg::*;

  logic [7:0] slice1_r, slice2_r, slice3_r;

  logic [1:0]  cond_r  [SLOTS];
  logic [1:0]  base_r  [SLOTS];
  logic [1:0]  rlvl_r  [SLOTS];
  logic [7:0]  slice_r [SLOTS];
  logic [31:0] sbeg_r  [SLOTS];
  logic [31:0] slen_r  [SLOTS];
  logic [SW-1:0] link_r [SLOTS];
  logic [SW-1:0] qhead_r [QUEUES];
  logic [SW-1:0] qtail_r [QUEUES];
  logic [CW-1:0] qcnt_r  [QUEUES];
  logic [SW-1:0] cur_r;
  logic          present_r;

  logic [2:0]  cmd_r;
  logic [SW-1:0] tid_r;
  logic [1:0]  lvl_r;
  logic [31:0] ticks_r, now_r;
  logic [1:0]  code_r;
  logic [SW-1:0] given_r;
  logic [SW-1:0] tmp_r;
  logic [SW-1:0] wptr_r;
  logic [CW-1:0] wleft_r;
  logic          out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  function automatic logic [7:0] slice_of(input logic [1:0] lv, input logic [7:0] s1,
                                          input logic [7:0] s2, input logic [7:0] s3);
    logic [7:0] r;
    case (lv)
      2'd0:    r = 8'd0;
      2'd1:    r = s1;
      2'd2:    r = s2;
      default: r = s3;
    endcase
    return r;
  endfunction

  logic          cur_run, pick_ok, spawn_ok, expired, wake, hit;
  logic [1:0]    pick_lv, spawn_lv, new_rl;
  logic [7:0]    new_sl;
  logic [SW-1:0] spawn_s, pop_s, push_s;
  logic          push_en, pop_en;
  logic [QW-1:0] push_q, pop_q;
  logic [31:0]   elapsed;

  always_comb begin
    cur_run = present_r && (cond_r[cur_r] == C_RUN);
    pick_ok = 1'b1;
    if (qcnt_r[3] != '0) pick_lv = 2'd3;
    else if (qcnt_r[2] != '0) pick_lv = 2'd2;
    else if (qcnt_r[1] != '0) pick_lv = 2'd1;
    else begin
      pick_lv = 2'd0;
      pick_ok = 1'b0;
    end
    spawn_ok = 1'b0;
    spawn_s  = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (cond_r[i] == C_FREE) begin
        spawn_ok = 1'b1;
        spawn_s  = SW'(i);
      end
    end
    spawn_lv = (lvl_r == 2'd0) ? 2'd1 : lvl_r;
    expired  = (slice_r[cur_r] <= 8'd1);
    if (expired) begin
      new_rl = (rlvl_r[cur_r] == 2'd0) ? 2'd0 : rlvl_r[cur_r] - 2'd1;
      new_sl = slice_of(new_rl, slice1_r, slice2_r, slice3_r);
    end else begin
      new_rl = rlvl_r[cur_r];
      new_sl = slice_r[cur_r] - 8'd1;
    end
    elapsed = now_r - sbeg_r[tmp_r];
    wake    = (elapsed >= slen_r[tmp_r]);
    hit     = (wleft_r != '0) && (wptr_r == tid_r);

    push_en = 1'b0;
    push_q  = '0;
    push_s  = '0;
    pop_en  = 1'b0;
    pop_q   = '0;
    case (ctl.op)
      OP_SPAWN: begin
        push_en = spawn_ok;
        push_q  = {1'b0, spawn_lv};
        push_s  = spawn_s;
      end
      OP_PRE: begin
        push_en = (cmd_r == CMD_SLEEP) && cur_run;
        push_q  = SLEEP_Q;
        push_s  = cur_r;
      end
      OP_CUR: begin
        push_en = cur_run;
        push_q  = {1'b0, new_rl};
        push_s  = cur_r;
      end
      OP_SPOP: begin
        pop_en = 1'b1;
        pop_q  = SLEEP_Q;
      end
      OP_SPUSH: begin
        push_en = (cond_r[tmp_r] == C_BLOCKED);
        push_q  = wake ? {1'b0, rlvl_r[tmp_r]} : SLEEP_Q;
        push_s  = tmp_r;
      end
      OP_PICK: begin
        pop_en = pick_ok;
        pop_q  = {1'b0, pick_lv};
      end
      OP_REFILL: begin
        pop_en  = 1'b1;
        pop_q   = '0;
        push_en = 1'b1;
        push_q  = {1'b0, base_r[qhead_r[0]]};
        push_s  = qhead_r[0];
      end
      OP_UNBLK: begin
        push_en = (cond_r[tid_r] == C_BLOCKED) && !hit;
        push_q  = {1'b0, rlvl_r[tid_r]};
        push_s  = tid_r;
      end
      default: ;
    endcase
    pop_s = qhead_r[pop_q];

    sts.cmd      = cmd_r;
    sts.sleep_nz = (qcnt_r[SLEEP_Q] != '0);
    sts.pick_ok  = pick_ok;
    sts.q0_nz    = (qcnt_r[0] != '0);
    sts.walk_end = (wleft_r == '0) || (wptr_r == tid_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  // Control state: conditions, queue pointers, running task, output valid, slice settings.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) cond_r[i] <= C_FREE;
      for (int q = 0; q < QUEUES; q++) begin
        qhead_r[q] <= '0;
        qtail_r[q] <= '0;
        qcnt_r[q]  <= '0;
      end
      cur_r       <= '0;
      present_r   <= 1'b0;
      out_valid_r <= 1'b0;
      slice1_r    <= 8'd8;
      slice2_r    <= 8'd4;
      slice3_r    <= 8'd2;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_SLICE1: slice1_r <= cfg_wdata;
          CFG_SLICE2: slice2_r <= cfg_wdata;
          CFG_SLICE3: slice3_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (pop_en) begin
        qhead_r[pop_q] <= link_r[pop_s];
        qcnt_r[pop_q]  <= qcnt_r[pop_q] - CW'(1);
      end
      if (push_en) begin
        if (qcnt_r[push_q] == '0) qhead_r[push_q] <= push_s;
        qtail_r[push_q] <= push_s;
        qcnt_r[push_q]  <= qcnt_r[push_q] + CW'(1);
      end
      // A new result word replaces the one taken in this same cycle.
      if (ctl.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (ctl.op)
        OP_SPAWN: if (spawn_ok) cond_r[spawn_s] <= C_READY;
        OP_PRE: begin
          if (cur_run) cond_r[cur_r] <= (cmd_r == CMD_EXIT) ? C_FREE : C_BLOCKED;
        end
        OP_CUR: if (cur_run) cond_r[cur_r] <= C_READY;
        OP_SPUSH: if (cond_r[tmp_r] == C_BLOCKED && wake) cond_r[tmp_r] <= C_READY;
        OP_PICK: begin
          present_r <= pick_ok;
          cur_r     <= pick_ok ? pop_s : '0;
          if (pick_ok) cond_r[pop_s] <= C_RUN;
        end
        OP_REFILL: cond_r[pop_s] <= C_READY;
        OP_UNBLK: if (push_en) cond_r[tid_r] <= C_READY;
        default: ;
      endcase
    end
  end

  // Payload state without reset.
  always_ff @(posedge clk) begin
    if (push_en && qcnt_r[push_q] != '0) link_r[qtail_r[push_q]] <= push_s;
    case (ctl.op)
      OP_LOAD: begin
        cmd_r   <= in_tdata[2:0];
        tid_r   <= in_tdata[6:3];
        lvl_r   <= in_tdata[8:7];
        ticks_r <= in_tdata[40:9];
        now_r   <= in_tdata[72:41];
        code_r  <= RC_OK;
        given_r <= '0;
      end
      OP_SPAWN: begin
        if (spawn_ok) begin
          base_r[spawn_s]  <= spawn_lv;
          rlvl_r[spawn_s]  <= spawn_lv;
          slice_r[spawn_s] <= slice_of(spawn_lv, slice1_r, slice2_r, slice3_r);
          given_r          <= spawn_s;
        end else begin
          code_r <= RC_NO_SLOT;
        end
      end
      OP_PRE: begin
        if (cur_run && cmd_r == CMD_SLEEP) begin
          sbeg_r[cur_r] <= now_r;
          slen_r[cur_r] <= ticks_r;
        end
      end
      OP_CUR: begin
        if (present_r) begin
          rlvl_r[cur_r]  <= new_rl;
          slice_r[cur_r] <= new_sl;
        end
      end
      OP_SPOP: tmp_r <= pop_s;
      OP_PICK: if (!pick_ok && qcnt_r[0] == '0) code_r <= RC_NO_RDY;
      OP_REFILL: begin
        rlvl_r[pop_s]  <= base_r[pop_s];
        slice_r[pop_s] <= slice_of(base_r[pop_s], slice1_r, slice2_r, slice3_r);
      end
      OP_WINIT: begin
        wptr_r  <= qhead_r[SLEEP_Q];
        wleft_r <= qcnt_r[SLEEP_Q];
      end
      OP_WSTEP: begin
        wptr_r  <= link_r[wptr_r];
        wleft_r <= wleft_r - CW'(1);
      end
      OP_UNBLK: if (!push_en) code_r <= RC_NOT_BLK;
      OP_OUT: begin
        out_data_r <= {3'b000, code_r, given_r,
                       present_r ? rlvl_r[cur_r] : 2'd0,
                       present_r, present_r ? cur_r : {SW{1'b0}}};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r[SLEEP_Q] <= CW'(SLOTS))
    else $error("sleep queue count exceeds slot count");
  a_pick_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_PICK && pick_ok) |=> present_r)
    else $error("pick did not start a task");
  a_refill_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_REFILL) |-> (qcnt_r[0] != '0))
    else $error("refill popped an empty level zero queue");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_OUT) |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken word");

endmodule

[sv/multilevel_feedback_task_scheduler.sv]
// Top level of the multilevel feedback task scheduler.
//
// One command word enters on the in_ channel and produces exactly one result
// word on the out_ channel. Commands schedule, spawn, sleep, unblock, block
// and exit tasks held in slots one to fifteen, four ready levels and a sleep
// queue. Slice lengths of levels one to three are set by the cfg_ write port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. A sleep, block or exit first updates the running
// task; a schedule, sleep, block or exit then requeues a still running task,
// checks the sleep queue head as an extra step when that queue is not empty,
// and picks from the highest nonempty level of three down to one. If all three
// are empty, the level zero queue goes back to its base levels one task per
// step before the pick is retried; an unblock walks the sleep queue until it
// finds the task or reaches its end. The sequencer handles one command at a
// time and in_tready rises again in the same cycle as out_tvalid.
// The result sits in an output register, so the next command is accepted
// while the previous word still waits; if the receiver keeps out_tready low,
// the next result waits in its final step until the register frees.
// After reset all slots are free, no task runs and the slices are 8, 4, 2.
module multilevel_feedback_task_scheduler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // cmd[2:0], task_id[6:3], start_level[8:7], sleep_ticks[40:9], now_time[72:41]
  input  logic [mfts_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // running_task[3:0], running_valid[4], running_level[6:5], new_task[10:7],
  // result_code[12:11]
  output logic [mfts_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_addr,
  input  logic [7:0]                   cfg_wdata
);
  import mfts_pkg::*;

  mfts_ctl_t ctl;
  mfts_sts_t sts;

  // The sequencer issues at most one datapath step per cycle.
  mfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // The datapath holds all task and queue state and the result register.
  mfts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
